// ----- hdl/pwdr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdr_pkg
// Shared types and constants of the pixel write depth reduction block.
// ----------------------------------------------------------------------------
package pwdr_pkg;

  localparam int DEF_MAX_DIM    = 4096;
  localparam int DEF_ADDR_WIDTH = 24;

  localparam int COLS_W  = 13;
  localparam int DEPTH_W = 6;
  localparam int PROD_W  = 2 * COLS_W;

  localparam logic [COLS_W-1:0]  COLS_RESET  = 13'd800;
  localparam logic [COLS_W-1:0]  ROWS_RESET  = 13'd600;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd32;

  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;

  localparam logic [31:0] BRIGHT_COLOR = 32'h00B8_C4D0;
  localparam logic [31:0] DARK_COLOR   = 32'h000D_1520;
  // luma/100 > 105 is the same as luma sum >= 10600
  localparam logic [14:0] LUMA_LIMIT   = 15'd10600;
  localparam logic [6:0]  LUMA_R       = 7'd30;
  localparam logic [6:0]  LUMA_G       = 7'd59;
  localparam logic [6:0]  LUMA_B       = 7'd11;
  localparam logic [13:0] ROUND_BIAS   = 14'd127;

  typedef enum logic [2:0] {
    MODE_PASS,
    MODE_KEEP,
    MODE_MONO,
    MODE_Q4,
    MODE_Q8,
    MODE_Q16
  } depth_mode_t;

  typedef struct packed {
    logic [COLS_W-1:0]  cols;
    logic [COLS_W-1:0]  rows;
    logic [DEPTH_W-1:0] depth;
  } cfg_t;

  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
  } pipe_ctl_t;

endpackage

// ----- hdl/pwdr_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdr_cfg
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module pwdr_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output pwdr_pkg::cfg_t cfg
);
  import pwdr_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_COLS:  cfg_nxt.cols  = pwdata[COLS_W-1:0];
        REG_ROWS:  cfg_nxt.rows  = pwdata[COLS_W-1:0];
        REG_DEPTH: cfg_nxt.depth = pwdata[DEPTH_W-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLS:  prdata = {{(32-COLS_W){1'b0}}, cfg_r.cols};
      REG_ROWS:  prdata = {{(32-COLS_W){1'b0}}, cfg_r.rows};
      REG_DEPTH: prdata = {{(32-DEPTH_W){1'b0}}, cfg_r.depth};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cols  <= COLS_RESET;
      cfg_r.rows  <= ROWS_RESET;
      cfg_r.depth <= DEPTH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/pwdr_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdr_geom
// Three-stage clip and linear address path: clip and multiply, add, mask.
// ----------------------------------------------------------------------------
module pwdr_geom #(
  parameter int MAX_DIM    = pwdr_pkg::DEF_MAX_DIM,
  parameter int ADDR_WIDTH = pwdr_pkg::DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  pwdr_pkg::pipe_ctl_t   ctl,
  input  pwdr_pkg::cfg_t        cfg,
  input  logic signed [15:0]    pos_x,
  input  logic signed [15:0]    pos_y,
  output logic                  on_screen,
  output logic [ADDR_WIDTH-1:0] pixel_address
);
  import pwdr_pkg::*;

  localparam logic [15:0] MAX_DIM_V = 16'(MAX_DIM);

  logic [COLS_W-1:0]     cols_eff;
  logic [COLS_W-1:0]     rows_eff;
  logic                  in_range;
  logic                  inside1_r;
  logic [PROD_W-1:0]     prod1_r;
  logic [COLS_W-1:0]     x1_r;
  logic                  inside2_r;
  logic [PROD_W-1:0]     addr2_r;
  logic                  inside3_r;
  logic [ADDR_WIDTH-1:0] addr3_r;
  logic [31:0]           addr_wide;

  assign cols_eff = ({3'd0, cfg.cols} > MAX_DIM_V) ? MAX_DIM_V[COLS_W-1:0] : cfg.cols;
  assign rows_eff = ({3'd0, cfg.rows} > MAX_DIM_V) ? MAX_DIM_V[COLS_W-1:0] : cfg.rows;

  assign in_range = !pos_x[15] && !pos_y[15]
                    && (pos_x[14:0] < {2'd0, cols_eff})
                    && (pos_y[14:0] < {2'd0, rows_eff});

  assign addr_wide = {{(32-PROD_W){1'b0}}, addr2_r};

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      inside1_r <= in_range;
      prod1_r   <= pos_y[COLS_W-1:0] * cols_eff;
      x1_r      <= pos_x[COLS_W-1:0];
    end
    if (ctl.s2_en) begin
      inside2_r <= inside1_r;
      addr2_r   <= prod1_r + {{(PROD_W-COLS_W){1'b0}}, x1_r};
    end
    if (ctl.s3_en) begin
      inside3_r <= inside2_r;
      addr3_r   <= inside2_r ? addr_wide[ADDR_WIDTH-1:0] : '0;
    end
  end

  assign on_screen     = inside3_r;
  assign pixel_address = addr3_r;

endmodule

// ----- hdl/pwdr_color.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdr_color
// Three-stage colour depth reduction: scale and luma, divide by 255, rescale.
// ----------------------------------------------------------------------------
module pwdr_color (
  input  logic                clk,
  input  pwdr_pkg::pipe_ctl_t ctl,
  input  pwdr_pkg::cfg_t      cfg,
  input  logic [31:0]         pixel_in,
  input  logic                raw_write,
  output logic [31:0]         pixel_out
);
  import pwdr_pkg::*;

  depth_mode_t mode;
  logic [5:0]  lvl_r;
  logic [5:0]  lvl_g;
  logic [5:0]  lvl_b;
  logic [14:0] luma;

  depth_mode_t mode1_r;
  logic [31:0] color1_r;
  logic [13:0] v_r1_r;
  logic [13:0] v_g1_r;
  logic [13:0] v_b1_r;
  logic        bright1_r;

  depth_mode_t mode2_r;
  logic [31:0] color2_r;
  logic [5:0]  q_r2_r;
  logic [5:0]  q_g2_r;
  logic [5:0]  q_b2_r;
  logic        bright2_r;

  logic [6:0]  st_r;
  logic [6:0]  st_g;
  logic [6:0]  st_b;
  logic [12:0] s_r;
  logic [12:0] s_g;
  logic [12:0] s_b;
  logic [31:0] color_nxt;
  logic [31:0] color3_r;

  function automatic logic [5:0] div255(input logic [13:0] v);
    logic [14:0] t;
    t = {1'b0, v} + 15'd1 + {7'd0, v[13:8]};
    return t[13:8];
  endfunction

  always_comb begin
    if (raw_write || cfg.depth >= 6'd24) begin
      mode = MODE_PASS;
    end else begin
      case (cfg.depth)
        6'd1:    mode = MODE_MONO;
        6'd4:    mode = MODE_Q4;
        6'd8:    mode = MODE_Q8;
        6'd16:   mode = MODE_Q16;
        default: mode = MODE_KEEP;
      endcase
    end
  end

  always_comb begin
    case (mode)
      MODE_Q8: begin
        lvl_r = 6'd7;  lvl_g = 6'd7;  lvl_b = 6'd3;
      end
      MODE_Q16: begin
        lvl_r = 6'd31; lvl_g = 6'd63; lvl_b = 6'd31;
      end
      default: begin
        lvl_r = 6'd3;  lvl_g = 6'd3;  lvl_b = 6'd3;
      end
    endcase
  end

  assign luma = 15'(pixel_in[23:16] * LUMA_R) + 15'(pixel_in[15:8] * LUMA_G)
              + 15'(pixel_in[7:0] * LUMA_B);

  always_comb begin
    case (mode2_r)
      MODE_Q8: begin
        st_r = 7'd36; st_g = 7'd36; st_b = 7'd85;
      end
      MODE_Q16: begin
        st_r = 7'd8;  st_g = 7'd4;  st_b = 7'd8;
      end
      default: begin
        st_r = 7'd85; st_g = 7'd85; st_b = 7'd85;
      end
    endcase
  end

  assign s_r = q_r2_r * st_r;
  assign s_g = q_g2_r * st_g;
  assign s_b = q_b2_r * st_b;

  always_comb begin
    case (mode2_r)
      MODE_PASS: color_nxt = color2_r;
      MODE_KEEP: color_nxt = {8'd0, color2_r[23:0]};
      MODE_MONO: color_nxt = bright2_r ? BRIGHT_COLOR : DARK_COLOR;
      MODE_Q4, MODE_Q8, MODE_Q16: color_nxt = {8'd0, s_r[7:0], s_g[7:0], s_b[7:0]};
      default:   color_nxt = color2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      mode1_r   <= mode;
      color1_r  <= pixel_in;
      v_r1_r    <= 14'(pixel_in[23:16] * lvl_r) + ROUND_BIAS;
      v_g1_r    <= 14'(pixel_in[15:8] * lvl_g) + ROUND_BIAS;
      v_b1_r    <= 14'(pixel_in[7:0] * lvl_b) + ROUND_BIAS;
      bright1_r <= luma >= LUMA_LIMIT;
    end
    if (ctl.s2_en) begin
      mode2_r   <= mode1_r;
      color2_r  <= color1_r;
      q_r2_r    <= div255(v_r1_r);
      q_g2_r    <= div255(v_g1_r);
      q_b2_r    <= div255(v_b1_r);
      bright2_r <= bright1_r;
    end
    if (ctl.s3_en) begin
      color3_r <= color_nxt;
    end
  end

  assign pixel_out = color3_r;

endmodule

// ----- hdl/pixel_write_depth_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_write_depth_reduce
// Clips pixel writes to the screen, forms the linear address and reduces the
// colour to the configured depth.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock through a three-stage pipeline
// whose last stage is the output register; stage one clips and multiplies y
// by the column count, stage two adds x and divides the scaled channels by
// 255, stage three rescales and picks the colour. Throughput is one word per
// cycle while the output is not stalled; a stalled output holds the last
// stage at once but stalls the input only once every stage is full.
// Configuration registers must be written while the pipeline is empty.
module pixel_write_depth_reduce #(
  parameter int MAX_DIM    = pwdr_pkg::DEF_MAX_DIM,
  parameter int ADDR_WIDTH = pwdr_pkg::DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_pos_x,
  input  logic signed [15:0]    in_pos_y,
  input  logic [31:0]           in_pixel_in,
  input  logic                  in_raw_write,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_write_enable,
  output logic [ADDR_WIDTH-1:0] out_pixel_address,
  output logic [31:0]           out_pixel_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import pwdr_pkg::*;

  cfg_t        cfg;
  pipe_ctl_t   ctl;
  logic        v1_r;
  logic        v2_r;
  logic        v3_r;
  logic        on_screen;
  logic [31:0] color;

  assign ctl.s3_en = !v3_r || !out_stall;
  assign ctl.s2_en = !v2_r || ctl.s3_en;
  assign ctl.s1_en = !v1_r || ctl.s2_en;
  assign in_stall  = !ctl.s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ctl.s1_en) v1_r <= in_valid;
      if (ctl.s2_en) v2_r <= v1_r;
      if (ctl.s3_en) v3_r <= v2_r;
    end
  end

  pwdr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pwdr_geom #(
    .MAX_DIM    (MAX_DIM),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_geom (
    .clk           (clk),
    .ctl           (ctl),
    .cfg           (cfg),
    .pos_x         (in_pos_x),
    .pos_y         (in_pos_y),
    .on_screen     (on_screen),
    .pixel_address (out_pixel_address)
  );

  pwdr_color u_color (
    .clk       (clk),
    .ctl       (ctl),
    .cfg       (cfg),
    .pixel_in  (in_pixel_in),
    .raw_write (in_raw_write),
    .pixel_out (color)
  );

  assign out_valid        = v3_r;
  assign out_write_enable = on_screen;
  assign out_pixel_out    = on_screen ? color : 32'd0;

endmodule

// ----- tb/sv/tb_pixel_write_depth_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_write_depth_reduce
// Self-checking bench for the pixel clip, address and colour depth block.
// ----------------------------------------------------------------------------
// Pixel words are driven through the valid/stall input channel while the
// register port sets the screen size and colour depth between phases. A
// scoreboard predicts the write enable, linear address and reduced colour of
// every accepted word and compares them field by field with the result
// channel, under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_pixel_write_depth_reduce;
  import pwdr_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          BATCH_WORDS    = 29;
  localparam logic [1:0]  REG_UNUSED     = 2'd3;
  localparam logic [5:0]  DEPTH_KEEP     = 6'd0;
  localparam logic [5:0]  DEPTH_MONO     = 6'd1;
  localparam logic [5:0]  DEPTH_ODD      = 6'd5;
  localparam logic [5:0]  DEPTH_Q4       = 6'd4;
  localparam logic [5:0]  DEPTH_Q8       = 6'd8;
  localparam logic [5:0]  DEPTH_Q16      = 6'd16;
  localparam logic [5:0]  DEPTH_FULL     = 6'd24;
  localparam logic [5:0]  DEPTH_TOP      = 6'd63;
  localparam logic [31:0] MONO_BRIGHT    = 32'h00B8_C4D0;
  localparam logic [31:0] MONO_DARK      = 32'h000D_1520;
  localparam int          MONO_THRESHOLD = 105;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        pixel_in;
    logic               raw_write;
  } pixel_word_t;

  typedef struct packed {
    logic                      write_enable;
    logic [DEF_ADDR_WIDTH-1:0] pixel_address;
    logic [31:0]               pixel_out;
  } pixel_write_t;

  class pixel_scoreboard;
    logic [COLS_W-1:0]  columns;
    logic [COLS_W-1:0]  rows;
    logic [DEPTH_W-1:0] depth;
    pixel_write_t       pending[$];
    int                 mismatches;
    int                 checked;

    function new();
      columns    = COLS_RESET;
      rows       = ROWS_RESET;
      depth      = DEPTH_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_COLS:  columns = val[COLS_W-1:0];
        REG_ROWS:  rows    = val[COLS_W-1:0];
        REG_DEPTH: depth   = val[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    function int span(logic [COLS_W-1:0] dim);
      return (dim > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(dim);
    endfunction

    function logic [7:0] quantise(logic [7:0] c, int levels, int step);
      int q;
      q = ((int'(c) * levels + 127) / 255) * step;
      return q[7:0];
    endfunction

    function logic [31:0] reduce_colour(logic [31:0] colour);
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      int         luma;
      red   = colour[23:16];
      green = colour[15:8];
      blue  = colour[7:0];
      if (depth >= DEPTH_FULL) return colour;
      case (depth)
        DEPTH_MONO: begin
          luma = (int'(red) * 30 + int'(green) * 59 + int'(blue) * 11) / 100;
          return (luma > MONO_THRESHOLD) ? MONO_BRIGHT : MONO_DARK;
        end
        DEPTH_Q4: begin
          red   = quantise(red, 3, 85);
          green = quantise(green, 3, 85);
          blue  = quantise(blue, 3, 85);
        end
        DEPTH_Q8: begin
          red   = quantise(red, 7, 36);
          green = quantise(green, 7, 36);
          blue  = quantise(blue, 3, 85);
        end
        DEPTH_Q16: begin
          red   = quantise(red, 31, 8);
          green = quantise(green, 63, 4);
          blue  = quantise(blue, 31, 8);
        end
        default: ;
      endcase
      return {8'h00, red, green, blue};
    endfunction

    function pixel_write_t predict_write(pixel_word_t w);
      pixel_write_t res;
      int           x;
      int           y;
      int           addr;
      x   = w.pos_x;
      y   = w.pos_y;
      res = '0;
      if (x >= 0 && y >= 0 && x < span(columns) && y < span(rows)) begin
        addr              = y * span(columns) + x;
        res.write_enable  = 1'b1;
        res.pixel_address = addr[DEF_ADDR_WIDTH-1:0];
        res.pixel_out     = w.raw_write ? w.pixel_in : reduce_colour(w.pixel_in);
      end
      return res;
    endfunction

    function void note_pixel(pixel_word_t w);
      pending.push_back(predict_write(w));
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(pixel_write_t got);
      pixel_write_t want;
      if (pending.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending.pop_front();
        checked++;
        if (got.write_enable !== want.write_enable)
          report_mismatch($sformatf("write_enable %0b, expected %0b",
                                    got.write_enable, want.write_enable));
        if (got.pixel_address !== want.pixel_address)
          report_mismatch($sformatf("pixel_address %h, expected %h",
                                    got.pixel_address, want.pixel_address));
        if (got.pixel_out !== want.pixel_out)
          report_mismatch($sformatf("pixel_out %h, expected %h",
                                    got.pixel_out, want.pixel_out));
      end
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [15:0]        in_pos_x;
  logic signed [15:0]        in_pos_y;
  logic [31:0]               in_pixel_in;
  logic                      in_raw_write;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_write_enable;
  logic [DEF_ADDR_WIDTH-1:0] out_pixel_address;
  logic [31:0]               out_pixel_out;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [3:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  pixel_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              words_sent;
  int              reg_writes;
  int              quiet_cycles;

  pixel_write_depth_reduce dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pixel_in       (in_pixel_in),
    .in_raw_write      (in_raw_write),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_enable  (out_write_enable),
    .out_pixel_address (out_pixel_address),
    .out_pixel_out     (out_pixel_out),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check accepted words, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_write_enable, out_pixel_address, out_pixel_out});
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task send_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                  input logic [31:0] colour, input logic raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pos_x     <= x;
    in_pos_y     <= y;
    in_pixel_in  <= colour;
    in_raw_write <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel('{x, y, colour, raw});
    words_sent++;
  endtask

  task wait_drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
    reg_writes++;
  endtask

  task set_screen(input logic [31:0] cols, input logic [31:0] rows,
                  input logic [DEPTH_W-1:0] depth);
    wait_drain();
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    write_reg(REG_DEPTH, {{(32-DEPTH_W){1'b0}}, depth});
  endtask

  function automatic logic [31:0] pick_dim();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom_range(DEF_MAX_DIM, 8191);
    if (r == 2) return 32'd1;
    if (r == 3) return DEF_MAX_DIM;
    if (r < 10) return $urandom_range(1, 64);
    return $urandom_range(1, DEF_MAX_DIM);
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    logic [5:0] common_depths[6];
    common_depths = '{DEPTH_MONO, DEPTH_Q4, DEPTH_Q8, DEPTH_Q16, DEPTH_FULL, DEPTH_RESET};
    if ($urandom_range(0, 3) != 0) return common_depths[$urandom_range(0, 5)];
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic signed [15:0] pick_coord(int lim);
    int r;
    r = $urandom_range(0, 9);
    if (lim > 0 && r < 7) return 16'($urandom_range(0, lim - 1));
    if (r == 7) return (lim > 0) ? 16'(lim - $urandom_range(0, 1)) : 16'(-1);
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_colour();
    logic [7:0] levels[4];
    levels = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    if ($urandom_range(0, 3) == 0)
      return {8'($urandom), levels[$urandom_range(0, 3)], levels[$urandom_range(0, 3)],
              levels[$urandom_range(0, 3)]};
    return $urandom;
  endfunction

  task random_batch(input int count);
    repeat (count)
      send_pixel(pick_coord(sb.span(sb.columns)), pick_coord(sb.span(sb.rows)),
                 pick_colour(), $urandom_range(0, 3) == 0);
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_pos_x      = '0;
    in_pos_y      = '0;
    in_pixel_in   = '0;
    in_raw_write  = 1'b0;
    out_stall     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    quiet_cycles  = 0;
    words_sent    = 0;
    reg_writes    = 0;
    send_idle_pct = 17;
    recv_idle_pct = 86;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset screen 800 x 600, full depth
    send_pixel(16'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b0);
    send_pixel(16'sd799, 16'sd599, 32'h1234_5678, 1'b0);
    send_pixel(16'sd800, 16'sd0, 32'h00FF_FFFF, 1'b0);
    send_pixel(16'sd0, 16'sd600, 32'h00FF_FFFF, 1'b0);
    send_pixel(-16'sd1, 16'sd5, 32'h0011_2233, 1'b0);
    send_pixel(16'sd5, -16'sd1, 32'h0011_2233, 1'b0);
    send_pixel(-16'sd32768, -16'sd32768, 32'hFFFF_FFFF, 1'b1);
    send_pixel(16'sd32767, 16'sd32767, 32'hFFFF_FFFF, 1'b0);
    send_pixel(16'sd10, 16'sd10, 32'hA5A5_A5A5, 1'b1);

    // mono threshold around luminance 105, largest address
    set_screen(DEF_MAX_DIM, DEF_MAX_DIM, DEPTH_MONO);
    send_pixel(16'sd4095, 16'sd4095, 32'h00FF_FFFF, 1'b0);
    send_pixel(16'sd1, 16'sd1, 32'h0069_6969, 1'b0);
    send_pixel(16'sd2, 16'sd2, 32'h006A_6A6A, 1'b0);
    send_pixel(16'sd3, 16'sd3, 32'h0000_0000, 1'b0);
    send_pixel(16'sd4, 16'sd4, 32'hFF00_0000, 1'b1);

    // oversized registers clamp to the largest screen
    set_screen(32'd8191, 32'd8191, DEPTH_Q4);
    send_pixel(16'sd4095, 16'sd4095, 32'hFF80_7F40, 1'b0);
    send_pixel(16'sd4096, 16'sd0, 32'h00FF_FFFF, 1'b0);
    send_pixel(16'sd0, 16'sd4096, 32'h00FF_FFFF, 1'b0);

    set_screen(32'd1, 32'd1, DEPTH_Q8);
    send_pixel(16'sd0, 16'sd0, 32'hFF80_FF7F, 1'b0);
    send_pixel(16'sd1, 16'sd0, 32'hFF80_FF7F, 1'b0);

    set_screen(32'd640, 32'd480, DEPTH_Q16);
    send_pixel(16'sd100, 16'sd200, 32'h00FF_8001, 1'b0);
    send_pixel(16'sd639, 16'sd479, 32'h12FF_FFFF, 1'b0);

    // zero width drops everything
    set_screen(32'd0, 32'd480, DEPTH_ODD);
    send_pixel(16'sd0, 16'sd0, 32'h0012_3456, 1'b0);

    // unlisted depth below full, and a write to an unmapped register
    set_screen(32'd320, 32'd240, DEPTH_KEEP);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pixel(16'sd0, 16'sd0, 32'hDEAD_BEEF, 1'b0);
    send_pixel(16'sd1, 16'sd1, 32'hDEAD_BEEF, 1'b1);
    send_pixel(16'sd319, 16'sd239, 32'hC0FF_EE11, 1'b0);

    set_screen(32'd33, 32'd17, DEPTH_TOP);
    send_pixel(16'sd32, 16'sd16, 32'hC0FF_EE11, 1'b0);

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 17 : (mode == 1) ? 86 : 0;
      recv_idle_pct = (mode == 0) ? 86 : (mode == 1) ? 17 : 0;
      for (int batch = 0; batch < 6; batch++) begin
        set_screen(pick_dim(), pick_dim(), pick_depth());
        random_batch(BATCH_WORDS);
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d expected words never came out",
                                   sb.pending.size()));
    $display("covered %0d pixel words under %0d register writes, %0d results checked",
             words_sent, reg_writes, sb.checked);
    $display("depths mono, 4, 8, 16, unlisted and full; clipped, oversized and empty screens");
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pwdr_pkg.sv
hdl/pwdr_cfg.sv
hdl/pwdr_geom.sv
hdl/pwdr_color.sv
hdl/pixel_write_depth_reduce.sv
tb/sv/tb_pixel_write_depth_reduce.sv
